// ===== rtl/crcpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger package
// Shared constants, codes, request type and the byte-wide CRC steps.
// ----------------------------------------------------------------------------
package crcpf_pkg;

    localparam logic [31:0] FWD_POLY = 32'hEDB88320;
    localparam logic [31:0] BWD_POLY = 32'hDB710641;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

    localparam logic [1:0] ADDR_TARGET = 2'd0;

    localparam int PATCH_BYTES = 4;
    localparam int IDX_W       = $clog2(PATCH_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PATCH_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_PREFIX = 2'd0,
        KIND_SUFFIX = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [31:0] fwd;
    } fin_req_t;

    function automatic logic [31:0] step_forward(input logic [31:0] r_in,
                                                 input logic [7:0]  b);
        logic [31:0] r;
        r = r_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? FWD_POLY : 32'd0);
        end
        return r;
    endfunction

    function automatic logic [31:0] step_backward(input logic [31:0] r_in,
                                                  input logic [7:0]  b);
        logic [31:0] r;
        r = r_in;
        for (int k = 0; k < 8; k++) begin
            r = (r << 1) ^ (r[31] ? BWD_POLY : 32'd0);
        end
        return r ^ {24'd0, b};
    endfunction

endpackage

// ===== rtl/crc32_patch_forger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger
// Finds four patch bytes that force a message's reflected CRC-32 to a target.
// ----------------------------------------------------------------------------
// Prefix and suffix bytes are taken one per cycle while s_tready is high and
// update their CRC registers in the cycle they are accepted. A finish request
// enters a four-stage pipeline, one backward byte step per stage, and its four
// patch bytes leave the output register lowest byte first, with tlast on the
// fourth, one beat per cycle while m_tready is high. A new patch is taken as the
// last byte of the previous one leaves; s_tready drops only while the pipeline
// holds a finished patch that the output register cannot yet take. target_crc
// is sampled by the first suffix byte, or by a finish if the message has none.
module crc32_patch_forger (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // patch_byte[7:0], patch_index[9:8], zero[15:10]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                target_sel;
    logic [31:0]         target_crc_reg;
    logic                accept;
    logic                advance;
    logic                fin_valid;
    logic [31:0]         fin_rem;
    logic                ser_free;
    crcpf_pkg::fin_req_t fin_req;

    assign target_sel = (paddr == crcpf_pkg::ADDR_TARGET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_crc_reg <= 32'd0;
        end else if (psel && penable && pwrite && pready && target_sel) begin
            target_crc_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = target_crc_reg;

    assign advance  = !fin_valid || ser_free;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    crcpf_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .kind       (s_tuser),
        .data_byte  (s_tdata),
        .target_crc (target_crc_reg),
        .fin_req    (fin_req)
    );

    crcpf_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .fin_req   (fin_req),
        .out_valid (fin_valid),
        .out_rem   (fin_rem)
    );

    crcpf_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fin_valid),
        .in_rem   (fin_rem),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/crcpf_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger accumulator
// Holds the forward and backward remainders and forms finish requests.
// ----------------------------------------------------------------------------
module crcpf_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          kind,
    input  logic [7:0]          data_byte,
    input  logic [31:0]         target_crc,
    output crcpf_pkg::fin_req_t fin_req
);

    logic [31:0] fwd_reg, fwd_next;
    logic [31:0] bwd_reg, bwd_next;
    logic        started_reg, started_next;
    logic [31:0] bwd_start;

    assign bwd_start = started_reg ? bwd_reg : ~target_crc;

    always_comb begin
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        started_next   = started_reg;
        fin_req.valid  = 1'b0;
        fin_req.rem    = bwd_start;
        fin_req.fwd    = fwd_reg;
        if (accept) begin
            unique case (crcpf_pkg::kind_t'(kind))
                crcpf_pkg::KIND_PREFIX: begin
                    fwd_next = crcpf_pkg::step_forward(fwd_reg, data_byte);
                end
                crcpf_pkg::KIND_SUFFIX: begin
                    bwd_next     = crcpf_pkg::step_backward(bwd_start, data_byte);
                    started_next = 1'b1;
                end
                crcpf_pkg::KIND_FINISH: begin
                    fin_req.valid = 1'b1;
                    fwd_next      = crcpf_pkg::ALL_ONES;
                    bwd_next      = 32'd0;
                    started_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg     <= crcpf_pkg::ALL_ONES;
            bwd_reg     <= 32'd0;
            started_reg <= 1'b0;
        end else begin
            fwd_reg     <= fwd_next;
            bwd_reg     <= bwd_next;
            started_reg <= started_next;
        end
    end

endmodule

// ===== rtl/crcpf_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger finish pipeline
// Runs the four forward-remainder bytes backward, one byte per stage.
// ----------------------------------------------------------------------------
module crcpf_finish (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  crcpf_pkg::fin_req_t fin_req,
    output logic                out_valid,
    output logic [31:0]         out_rem
);

    localparam int STAGES = crcpf_pkg::PATCH_BYTES;

    logic [STAGES-1:0] valid_reg;
    logic [31:0]       rem_reg [STAGES];
    logic [31:0]       fwd_reg [STAGES];
    logic [31:0]       rem_next [STAGES];

    assign rem_next[0] = crcpf_pkg::step_backward(fin_req.rem, fin_req.fwd[31:24]);

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        assign rem_next[k] = crcpf_pkg::step_backward(rem_reg[k-1],
                                                      fwd_reg[k-1][8*(STAGES-1-k) +: 8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[STAGES-2:0], fin_req.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0] <= rem_next[0];
            fwd_reg[0] <= fin_req.fwd;
            for (int k = 1; k < STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                fwd_reg[k] <= fwd_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];

endmodule

// ===== rtl/crcpf_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger output serializer
// Holds a finished patch and sends its four bytes lowest first.
// ----------------------------------------------------------------------------
module crcpf_serial (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [31:0] in_rem,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // patch_byte[7:0], patch_index[9:8], zero[15:10]
    output logic        m_tlast
);

    logic                        valid_reg;
    logic [crcpf_pkg::IDX_W-1:0] idx_reg;
    logic [31:0]                 rem_reg;
    logic                        at_last;

    assign at_last = (idx_reg == crcpf_pkg::LAST_IDX);
    assign free    = !valid_reg || (m_tready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (in_valid && free) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && free) begin
            rem_reg <= in_rem;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, idx_reg, rem_reg[{idx_reg, 3'b000} +: 8]};
    assign m_tlast  = at_last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 patch forger testbench
// Streams prefix, suffix and finish requests into the block, predicts the four
// patch bytes of every finish with a local CRC model and checks each output
// beat in order. The target register is swept over its extremes through the
// APB port, and the run passes through phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 6;
    localparam int          SETTLE       = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SHOWN_ERRORS = 10;
    localparam int          PHASE_ITEMS  = 64;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_POLY_REV = 32'hDB710641;

    typedef struct packed {
        logic [7:0] pbyte;
        logic [1:0] pidx;
        logic       plast;
    } patch_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // patch_byte[7:0], patch_index[9:8], zero[15:10]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] target_model;
    logic [31:0] fwd_model;
    logic [31:0] bwd_model;
    logic        suffix_seen;

    patch_beat_t patch_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int error_count;
    int requests_sent;
    int requests_counted;
    int beats_checked;
    int patches_done;
    int targets_written;

    crc32_patch_forger uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, patch_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] crc_fwd_byte(logic [31:0] r, logic [7:0] b);
        logic [31:0] v;
        v = r ^ {24'h0, b};
        repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic logic [31:0] crc_bwd_byte(logic [31:0] r, logic [7:0] b);
        logic [31:0] v;
        v = r;
        repeat (8) v = v[31] ? ((v << 1) ^ CRC_POLY_REV) : (v << 1);
        return v ^ {24'h0, b};
    endfunction

    task automatic clear_message_model();
        fwd_model   = 32'hFFFFFFFF;
        bwd_model   = 32'h0;
        suffix_seen = 1'b0;
    endtask

    task automatic predict_request(logic [1:0] kind, logic [7:0] data);
        logic [31:0] r;
        patch_beat_t beat;
        case (kind)
            crcpf_pkg::KIND_PREFIX: begin
                fwd_model = crc_fwd_byte(fwd_model, data);
            end
            crcpf_pkg::KIND_SUFFIX: begin
                if (!suffix_seen) begin
                    bwd_model   = ~target_model;
                    suffix_seen = 1'b1;
                end
                bwd_model = crc_bwd_byte(bwd_model, data);
            end
            crcpf_pkg::KIND_FINISH: begin
                r = suffix_seen ? bwd_model : ~target_model;
                for (int i = 3; i >= 0; i--) begin
                    r = crc_bwd_byte(r, fwd_model[8*i +: 8]);
                end
                for (int i = 0; i < 4; i++) begin
                    beat.pbyte = r[8*i +: 8];
                    beat.pidx  = 2'(i);
                    beat.plast = (i == 3);
                    patch_q.push_back(beat);
                end
                patches_done++;
                clear_message_model();
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_request(logic [1:0] kind, logic [7:0] data);
        forever begin
            @(negedge aclk);
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid = 1'b0;
            end else begin
                s_tvalid = 1'b1;
                s_tuser  = kind;
                s_tdata  = data;
                break;
            end
        end
        do @(posedge aclk); while (!s_tready);
        predict_request(kind, data);
        requests_sent++;
        if (kind != KIND_UNUSED) requests_counted++;
    endtask

    task automatic wait_for_patches();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (patch_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = crcpf_pkg::ADDR_TARGET;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_target(logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        target_model = value;
        targets_written++;
        apb_access(1'b0, 32'h0, rd);
        if (rd !== value) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display("Target readback mismatch: expected %08h, actual %08h",
                         value, rd);
        end
    endtask

    always @(posedge aclk) begin
        patch_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (patch_q.size() == 0) begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("Unexpected patch beat: byte %02h index %0d last %0b",
                             m_tdata[7:0], m_tdata[9:8], m_tlast);
            end else begin
                want = patch_q.pop_front();
                if (m_tdata[7:0] !== want.pbyte || m_tdata[9:8] !== want.pidx ||
                    m_tdata[15:10] !== 6'd0 || m_tlast !== want.plast) begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display({"Patch beat mismatch: expected byte %02h index %0d",
                                  " last %0b, actual byte %02h index %0d last %0b pad %02h"},
                                 want.pbyte, want.pidx, want.plast, m_tdata[7:0],
                                 m_tdata[9:8], m_tlast, m_tdata[15:10]);
                end
            end
        end
    end

    // Empty messages, ignored kinds, byte extremes, a prefix byte after the
    // suffix and a finish carrying a nonzero data byte.
    task automatic test_directed_messages();
        send_request(crcpf_pkg::KIND_FINISH, 8'h00);
        send_request(KIND_UNUSED, 8'hFF);
        send_request(KIND_UNUSED, 8'h00);
        send_request(crcpf_pkg::KIND_PREFIX, 8'h00);
        send_request(crcpf_pkg::KIND_PREFIX, 8'hFF);
        send_request(crcpf_pkg::KIND_FINISH, 8'hFF);
        send_request(crcpf_pkg::KIND_SUFFIX, 8'hFF);
        send_request(crcpf_pkg::KIND_SUFFIX, 8'h00);
        send_request(crcpf_pkg::KIND_PREFIX, 8'hA5);
        send_request(crcpf_pkg::KIND_FINISH, 8'h5A);
        wait_for_patches();
    endtask

    // The target is captured by the first suffix byte; a write after that
    // only applies to the following message.
    task automatic test_target_capture();
        set_target(32'hFFFFFFFF);
        send_request(crcpf_pkg::KIND_SUFFIX, 8'h12);
        wait_for_patches();
        set_target(32'h00000000);
        send_request(crcpf_pkg::KIND_FINISH, 8'h00);
        send_request(crcpf_pkg::KIND_FINISH, 8'h00);
        wait_for_patches();
    endtask

    task automatic test_target_extremes();
        logic [31:0] targets[4];
        targets = '{32'h80000000, 32'h00000001, 32'hFFFFFFFF, $urandom};
        foreach (targets[i]) begin
            set_target(targets[i]);
            send_request(crcpf_pkg::KIND_PREFIX, 8'($urandom));
            send_request(crcpf_pkg::KIND_SUFFIX, 8'($urandom));
            send_request(crcpf_pkg::KIND_FINISH, 8'($urandom));
            wait_for_patches();
        end
    endtask

    task automatic send_random_message();
        int n_pre;
        int n_suf;
        n_pre = $urandom_range(0, 8);
        n_suf = $urandom_range(0, 6);
        repeat (n_pre) begin
            if ($urandom_range(9) == 0) send_request(KIND_UNUSED, 8'($urandom));
            send_request(crcpf_pkg::KIND_PREFIX, 8'($urandom));
        end
        repeat (n_suf) begin
            if ($urandom_range(9) == 0) send_request(KIND_UNUSED, 8'($urandom));
            send_request(crcpf_pkg::KIND_SUFFIX, 8'($urandom));
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3))
                send_request(crcpf_pkg::KIND_PREFIX, 8'($urandom));
        end
        if ($urandom_range(9) != 0) send_request(crcpf_pkg::KIND_FINISH, 8'($urandom));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, logic [31:0] target,
                                     logic hold_off);
        int start_count;
        logic paused;
        paused         = 1'b0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_target(target);
        start_count = requests_counted;
        while (requests_counted - start_count < PHASE_ITEMS) begin
            send_random_message();
            if (hold_off && !paused && requests_counted - start_count > PHASE_ITEMS / 2) begin
                wait_for_patches();
                paused = 1'b1;
            end
        end
        send_request(crcpf_pkg::KIND_FINISH, 8'($urandom));
        wait_for_patches();
    endtask

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'h00;
        s_tuser          = crcpf_pkg::KIND_PREFIX;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = crcpf_pkg::ADDR_TARGET;
        pwdata           = 32'h0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        error_count      = 0;
        requests_sent    = 0;
        requests_counted = 0;
        patches_done     = 0;
        targets_written  = 0;
        target_model     = 32'h0;
        clear_message_model();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_messages();
        test_target_capture();
        test_target_extremes();
        test_random_phase(0, 0, $urandom, 1'b0);
        test_random_phase(70, 0, 32'h00000000, 1'b1);
        test_random_phase(0, 70, 32'hFFFFFFFF, 1'b0);
        test_random_phase(10, 10, $urandom, 1'b0);

        wait_for_patches();
        $display("Sent %0d requests, checked %0d patch beats from %0d finishes.",
                 requests_sent, beats_checked, patches_done);
        $display("Target written %0d times, four idling phases, %0d errors.",
                 targets_written, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
